[src/shfp_pkg.sv]
// Types and constants for the sync-header frame parser.
// No dependencies; used by shfp_if.sv and sync_header_frame_parser.sv.
package shfp_pkg;

  localparam logic [7:0] HDR_FIRST  = 8'hAA;
  localparam logic [7:0] HDR_SECOND = 8'h55;
  localparam int unsigned FRAME_LEN = 8;

  typedef logic [7:0]  byte_t;
  typedef logic [31:0] angle_t;

  typedef enum logic {
    ACT_BYTE     = 1'b0,
    ACT_LINE_ERR = 1'b1
  } action_t;

  // byte position within the frame
  typedef enum logic [2:0] {
    POS_HUNT  = 3'd0,
    POS_HDR2  = 3'd1,
    POS_A0    = 3'd2,
    POS_A1    = 3'd3,
    POS_A2    = 3'd4,
    POS_A3    = 3'd5,
    POS_RSVD  = 3'd6,
    POS_CHECK = 3'd7
  } pos_t;

  localparam int unsigned EXP_LSB = 23;
  localparam int unsigned EXP_MSB = 30;

endpackage

[src/shfp_if.sv]
// Valid/ready channel interfaces for the sync-header frame parser.
// Depends on shfp_pkg.
interface shfp_in_if;
  import shfp_pkg::*;
  logic    valid;
  logic    ready;
  action_t action;
  byte_t   rx_byte;

  modport source (output valid, output action, output rx_byte, input ready);
  modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

interface shfp_out_if;
  import shfp_pkg::*;
  logic   valid;
  logic   ready;
  angle_t angle_word;

  modport source (output valid, output angle_word, input ready);
  modport sink   (input valid, input angle_word, output ready);
endinterface

[src/sync_header_frame_parser.sv]
// Deframer for 8-byte frames (0xAA 0x55, angle word LE, reserved, XOR checksum).
// Depends on shfp_pkg and the channel interfaces in shfp_if.sv.
//
//  channel | dir | handshake      | payload
//  in_ch   | in  | valid / ready  | action (1), rx_byte (8)
//  out_ch  | out | valid / ready  | angle_word (32)
//
// One byte per cycle sustained while out_ch is not stalled. A byte is held in the
// input register, then the frame state update and the frame check run in one pass into
// the result register. out_ch.valid rises when the checksum byte passes from the input
// register into the result register and the frame checks good.
// Reset (synchronous, rst_n low) empties both registers and returns to hunt.
// A stalled result holds the input register; in_ch.ready drops only then.
module sync_header_frame_parser (
  input logic       clk,
  input logic       rst_n,
  shfp_in_if.sink   in_ch,
  shfp_out_if.source out_ch
);
  import shfp_pkg::*;

  // input register
  logic    s1_valid_r;
  action_t s1_action_r;
  byte_t   s1_byte_r;

  // frame state
  pos_t   pos_r, pos_nxt;
  byte_t  xor_r, xor_nxt;
  angle_t angle_r, angle_nxt;
  byte_t  rsvd_r, rsvd_nxt;

  // result register
  logic   out_valid_r, out_valid_nxt;
  angle_t out_angle_r;

  logic s1_fire;
  logic frame_ok;

  assign s1_fire      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_fire;
  assign out_ch.valid = out_valid_r;
  assign out_ch.angle_word = out_angle_r;

  assign frame_ok = (s1_byte_r == xor_r) && (rsvd_r == '0) &&
                    (angle_r[EXP_MSB:EXP_LSB] != 8'hFF);

  always_comb begin
    pos_nxt   = pos_r;
    xor_nxt   = xor_r;
    angle_nxt = angle_r;
    rsvd_nxt  = rsvd_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (s1_fire) begin
      out_valid_nxt = 1'b0;
      if (s1_action_r == ACT_LINE_ERR) begin
        pos_nxt   = POS_HUNT;
        xor_nxt   = '0;
        angle_nxt = '0;
        rsvd_nxt  = '0;
      end else begin
        case (pos_r)
          POS_HUNT: begin
            if (s1_byte_r == HDR_FIRST) begin
              xor_nxt = HDR_FIRST;
              pos_nxt = POS_HDR2;
            end
          end
          POS_HDR2: begin
            if (s1_byte_r == HDR_SECOND) begin
              xor_nxt = xor_r ^ s1_byte_r;
              pos_nxt = POS_A0;
            end else if (s1_byte_r == HDR_FIRST) begin
              // repeated first header byte: re-arm
              xor_nxt = HDR_FIRST;
              pos_nxt = POS_HDR2;
            end else begin
              pos_nxt = POS_HUNT;
            end
          end
          POS_A0, POS_A1, POS_A2, POS_A3: begin
            // little-endian: shift new byte in from the top
            angle_nxt = {s1_byte_r, angle_r[31:8]};
            xor_nxt   = xor_r ^ s1_byte_r;
            pos_nxt   = pos_t'(pos_r + 3'd1);
          end
          POS_RSVD: begin
            rsvd_nxt = s1_byte_r;
            xor_nxt  = xor_r ^ s1_byte_r;
            pos_nxt  = POS_CHECK;
          end
          POS_CHECK: begin
            out_valid_nxt = frame_ok;
            pos_nxt       = POS_HUNT;
          end
          default: begin
            pos_nxt = POS_HUNT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= POS_HUNT;
      xor_r       <= '0;
      angle_r     <= '0;
      rsvd_r      <= '0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
      xor_r       <= xor_nxt;
      angle_r     <= angle_nxt;
      rsvd_r      <= rsvd_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_action_r <= in_ch.action;
      s1_byte_r   <= in_ch.rx_byte;
    end
    if (s1_fire && (s1_action_r == ACT_BYTE) && (pos_r == POS_CHECK)) begin
      out_angle_r <= angle_r;
    end
  end

  a_line_err_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_action_r == ACT_LINE_ERR) |=> (pos_r == POS_HUNT && xor_r == '0))
    else $error("line error did not return parser to hunt");

  a_check_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_action_r == ACT_BYTE && pos_r == POS_CHECK) |=> (pos_r == POS_HUNT))
    else $error("checksum byte did not end the frame");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(pos_r) == POS_CHECK && $past(s1_fire)))
    else $error("result raised outside the checksum byte");

  a_result_finite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_angle_r[EXP_MSB:EXP_LSB] != 8'hFF))
    else $error("non-finite angle word emitted");

endmodule
